// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker (src/rfs_checker.sv).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfs assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfs assertion failed");

`endif

// ===== src/rfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes for the range filter sorted store.
// No dependencies.
package rfs_pkg;

    localparam int RFS_DEPTH    = 1024;
    localparam int RFS_GRP      = 32;
    localparam int RFS_NGRP     = (RFS_DEPTH + RFS_GRP - 1) / RFS_GRP;
    localparam int RFS_PADW     = RFS_NGRP * RFS_GRP;
    localparam int RFS_LOG_GRP  = $clog2(RFS_GRP);
    localparam int RFS_LOG_NGRP = $clog2(RFS_NGRP);
    localparam int RFS_CNT_W    = $clog2(RFS_DEPTH + 1);
    localparam int RFS_REM_W    = 11;
    localparam int RFS_KEY_W    = 24;
    localparam int RFS_AGE_W    = 8;
    localparam int RFS_WGT_W    = 24;
    localparam int RFS_LINE_W   = 32;
    localparam int RFS_CFG_IDX_W  = 3;
    localparam int RFS_CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [RFS_CFG_IDX_W-1:0] {
        REG_AGE_LOW     = 3'd0,
        REG_AGE_HIGH    = 3'd1,
        REG_WEIGHT_LOW  = 3'd2,
        REG_WEIGHT_HIGH = 3'd3,
        REG_SORT_WEIGHT = 3'd4,
        REG_DESCENDING  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GRP,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic [RFS_AGE_W-1:0]  age;
        logic [RFS_WGT_W-1:0]  weight;
        logic [RFS_LINE_W-1:0] line;
    } rec_t;

    typedef struct packed {
        logic key_weight;
        logic descending;
    } order_t;

    typedef struct packed {
        logic cmp_en;
        logic pop_shift;
        logic ins_shift;
    } cell_ctl_t;

    function automatic logic [RFS_KEY_W-1:0] rec_key(input logic [RFS_AGE_W-1:0] age,
                                                     input logic [RFS_WGT_W-1:0] weight,
                                                     input logic by_weight);
        logic [RFS_KEY_W-1:0] k;
        k = by_weight ? weight : RFS_KEY_W'(age);
        return k;
    endfunction

endpackage

// ===== src/rfs_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted record row: holds a record and its compare flag.
// Depends on rfs_pkg.
module rfs_cell
    import rfs_pkg::*;
(
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  order_t               order,
    input  logic                 occ,
    input  logic                 at_self,
    input  logic                 at_prev,
    input  logic [RFS_KEY_W-1:0] new_key,
    input  rec_t                 new_rec,
    input  rec_t                 left_rec,
    input  rec_t                 right_rec,
    output rec_t                 rec,
    output logic                 strict
);

    rec_t                 rec_reg;
    rec_t                 rec_next;
    logic                 strict_reg;
    logic                 strict_next;
    logic [RFS_KEY_W-1:0] own_key;

    always_comb
    begin
        own_key = rec_key(rec_reg.age, rec_reg.weight, order.key_weight);
        // stored entry sorts strictly after the incoming one
        if (order.descending)
        begin
            strict_next = occ && (own_key < new_key);
        end
        else
        begin
            strict_next = occ && (own_key > new_key);
        end
    end

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.pop_shift)
        begin
            rec_next = right_rec;
        end
        else if (ctl.ins_shift && at_self)
        begin
            rec_next = at_prev ? left_rec : new_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (ctl.cmp_en)
        begin
            strict_reg <= strict_next;
        end
    end

    assign rec    = rec_reg;
    assign strict = strict_reg;

endmodule

// ===== src/rfs_prefix.sv =====
`timescale 1ns / 1ps
// Two-level registered prefix OR over the cell compare flags.
// Depends on rfs_pkg.
module rfs_prefix
    import rfs_pkg::*;
(
    input  logic                 clk,
    input  logic [RFS_DEPTH-1:0] strict,
    output logic [RFS_DEPTH-1:0] hit
);

    logic [RFS_PADW-1:0] pad;
    logic [RFS_PADW-1:0] inpfx_next;
    logic [RFS_PADW-1:0] inpfx_reg;
    logic [RFS_NGRP-1:0] any_next;
    logic [RFS_NGRP-1:0] any_reg;
    logic [RFS_NGRP-1:0] grp_incl;
    logic [RFS_NGRP-1:0] grp_before;

    assign pad = RFS_PADW'(strict);

    // in-group prefix, log-step form
    always_comb
    begin
        logic [RFS_GRP-1:0] v;
        logic [RFS_GRP-1:0] nv;
        inpfx_next = '0;
        any_next   = '0;
        for (int g = 0; g < RFS_NGRP; g++)
        begin
            v = pad[g*RFS_GRP +: RFS_GRP];
            for (int s = 0; s < RFS_LOG_GRP; s++)
            begin
                nv = v;
                for (int k = 0; k < RFS_GRP; k++)
                begin
                    if (k >= (1 << s))
                    begin
                        nv[k] = v[k] | v[k - (1 << s)];
                    end
                end
                v = nv;
            end
            inpfx_next[g*RFS_GRP +: RFS_GRP] = v;
            any_next[g] = v[RFS_GRP-1];
        end
    end

    always_ff @(posedge clk)
    begin
        inpfx_reg <= inpfx_next;
        any_reg   <= any_next;
    end

    // prefix across groups
    always_comb
    begin
        logic [RFS_NGRP-1:0] gv;
        logic [RFS_NGRP-1:0] gn;
        gv = any_reg;
        for (int s = 0; s < RFS_LOG_NGRP; s++)
        begin
            gn = gv;
            for (int k = 0; k < RFS_NGRP; k++)
            begin
                if (k >= (1 << s))
                begin
                    gn[k] = gv[k] | gv[k - (1 << s)];
                end
            end
            gv = gn;
        end
        grp_incl = gv;
        grp_before = {grp_incl[RFS_NGRP-2:0], 1'b0};
    end

    always_comb
    begin
        for (int i = 0; i < RFS_DEPTH; i++)
        begin
            hit[i] = inpfx_reg[i] | grp_before[i / RFS_GRP];
        end
    end

endmodule

// ===== src/range_filter_sorted_store.sv =====
`timescale 1ns / 1ps
// Pop: result strobed on done the cycle after acceptance; one pop or clear per cycle if idle.
// Stored insert: busy through ST_GRP and ST_SHIFT, so no command is taken until it ends
// (flag compare in every cell, registered prefix OR across the row, then row shift).
// A dropped insert or an unused command leaves the FSM idle. Results cannot be stalled.
// Reset clears count, overflow, done, FSM and order, opens windows; cells are not cleared.
module range_filter_sorted_store
    import rfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                command,
    input  logic [RFS_AGE_W-1:0]      rec_age,
    input  logic [RFS_WGT_W-1:0]      rec_weight,
    input  logic [RFS_LINE_W-1:0]     line_number,
    input  logic                      cfg_we,
    input  logic [RFS_CFG_IDX_W-1:0]  cfg_idx,
    input  logic [RFS_CFG_DATA_W-1:0] cfg_wdata,
    output logic                      done,
    output logic [RFS_AGE_W-1:0]      out_age,
    output logic [RFS_WGT_W-1:0]      out_weight,
    output logic [RFS_LINE_W-1:0]     out_line,
    output logic                      out_valid,
    output logic [RFS_REM_W-1:0]      remaining,
    output logic                      overflow
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [RFS_CNT_W-1:0]   count_reg;
    logic [RFS_CNT_W-1:0]   count_next;
    logic                   overflow_reg;
    logic                   overflow_next;
    logic [RFS_AGE_W-1:0]   age_low_reg;
    logic [RFS_AGE_W-1:0]   age_high_reg;
    logic [RFS_WGT_W-1:0]   weight_low_reg;
    logic [RFS_WGT_W-1:0]   weight_high_reg;
    order_t                 order_reg;
    rec_t                   new_rec_reg;
    logic                   done_reg;
    rec_t                   out_rec_reg;
    logic                   out_valid_reg;
    logic [RFS_REM_W-1:0]   remaining_reg;

    logic                   accept;
    logic                   cmd_ins;
    logic                   cmd_pop;
    logic                   cmd_clr;
    logic                   pass;
    logic                   full;
    logic                   ins_go;
    logic                   in_shift;
    logic [RFS_KEY_W-1:0]   in_key;
    cell_ctl_t              ctl;
    rec_t                   in_rec;
    rec_t                   cell_rec [RFS_DEPTH];
    logic [RFS_DEPTH-1:0]   strict;
    logic [RFS_DEPTH-1:0]   hit;
    logic [RFS_DEPTH-1:0]   occ;
    logic [RFS_DEPTH-1:0]   at;

    assign accept = start && !busy;

    always_comb
    begin
        cmd_ins = 1'b0;
        cmd_pop = 1'b0;
        cmd_clr = 1'b0;
        case (cmd_t'(command))
            CMD_INSERT: cmd_ins = 1'b1;
            CMD_POP:    cmd_pop = 1'b1;
            CMD_CLEAR:  cmd_clr = 1'b1;
            default:    ;
        endcase
    end

    assign pass = (rec_age >= age_low_reg) && (rec_age <= age_high_reg)
               && (rec_weight >= weight_low_reg) && (rec_weight <= weight_high_reg);
    assign full   = (count_reg >= RFS_CNT_W'(RFS_DEPTH));
    assign ins_go = accept && cmd_ins && pass && !full;
    assign in_key = rec_key(rec_age, rec_weight, order_reg.key_weight);
    assign in_rec = '{age: rec_age, weight: rec_weight, line: line_number};

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = ins_go ? ST_GRP : ST_IDLE;
            ST_GRP:   state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        busy     = 1'b0;
        in_shift = 1'b0;
        case (state_reg)
            ST_IDLE:  ;
            ST_GRP:   busy = 1'b1;
            ST_SHIFT:
            begin
                busy     = 1'b1;
                in_shift = 1'b1;
            end
            default:  ;
        endcase
    end

    assign ctl.cmp_en    = accept && cmd_ins;
    assign ctl.pop_shift = accept && cmd_pop && (count_reg != '0);
    assign ctl.ins_shift = in_shift;

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (accept && cmd_clr)
        begin
            count_next = '0;
        end
        else if (ctl.pop_shift)
        begin
            count_next = count_reg - RFS_CNT_W'(1);
        end
        else if (in_shift)
        begin
            count_next = count_reg + RFS_CNT_W'(1);
        end
        if (accept && cmd_ins && pass && full)
        begin
            overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            done_reg        <= 1'b0;
            age_low_reg     <= '0;
            age_high_reg    <= '1;
            weight_low_reg  <= '0;
            weight_high_reg <= '1;
            order_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            done_reg     <= accept && cmd_pop;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_idx))
                    REG_AGE_LOW:     age_low_reg <= cfg_wdata[RFS_AGE_W-1:0];
                    REG_AGE_HIGH:    age_high_reg <= cfg_wdata[RFS_AGE_W-1:0];
                    REG_WEIGHT_LOW:  weight_low_reg <= cfg_wdata[RFS_WGT_W-1:0];
                    REG_WEIGHT_HIGH: weight_high_reg <= cfg_wdata[RFS_WGT_W-1:0];
                    REG_SORT_WEIGHT: order_reg.key_weight <= cfg_wdata[0];
                    REG_DESCENDING:  order_reg.descending <= cfg_wdata[0];
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && cmd_ins)
        begin
            new_rec_reg <= in_rec;
        end
        if (accept && cmd_pop)
        begin
            if (count_reg != '0)
            begin
                out_rec_reg   <= cell_rec[0];
                out_valid_reg <= 1'b1;
                remaining_reg <= RFS_REM_W'(count_reg - RFS_CNT_W'(1));
            end
            else
            begin
                out_rec_reg   <= '0;
                out_valid_reg <= 1'b0;
                remaining_reg <= '0;
            end
        end
    end

    // insert point: first occupied cell that sorts strictly after, else the fill end
    always_comb
    begin
        for (int i = 0; i < RFS_DEPTH; i++)
        begin
            occ[i] = count_reg > RFS_CNT_W'(i);
            at[i]  = hit[i] | !occ[i];
        end
    end

    rfs_prefix u_prefix (
        .clk    (clk),
        .strict (strict),
        .hit    (hit)
    );

    for (genvar i = 0; i < RFS_DEPTH; i++)
    begin : g_cell
        rfs_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .order     (order_reg),
            .occ       (occ[i]),
            .at_self   (at[i]),
            .at_prev   ((i == 0) ? 1'b0 : at[(i == 0) ? 0 : i - 1]),
            .new_key   (in_key),
            .new_rec   (new_rec_reg),
            .left_rec  ((i == 0) ? new_rec_reg : cell_rec[(i == 0) ? 0 : i - 1]),
            .right_rec ((i == RFS_DEPTH - 1) ? cell_rec[i]
                                             : cell_rec[(i == RFS_DEPTH - 1) ? i : i + 1]),
            .rec       (cell_rec[i]),
            .strict    (strict[i])
        );
    end

    assign done       = done_reg;
    assign out_age    = out_rec_reg.age;
    assign out_weight = out_rec_reg.weight;
    assign out_line   = out_rec_reg.line;
    assign out_valid  = out_valid_reg;
    assign remaining  = remaining_reg;
    assign overflow   = overflow_reg;

endmodule

// ===== src/rfs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the range filter sorted store, bound to the top level.
// Depends on rfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rfs_checker
    import rfs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [1:0]            command,
    input logic                  done,
    input logic                  out_valid,
    input logic [RFS_AGE_W-1:0]  out_age,
    input logic [RFS_WGT_W-1:0]  out_weight,
    input logic [RFS_LINE_W-1:0] out_line,
    input logic [RFS_REM_W-1:0]  remaining
);

    logic pop_accept;
    logic result_zero;

    assign pop_accept  = start && !busy && (command == CMD_POP);
    assign result_zero = (out_age == '0) && (out_weight == '0)
                      && (out_line == '0) && (remaining == '0);

    `RFS_ASSERT_NXT(a_pop_gives_result, clk, rst_n, pop_accept, done)
    `RFS_ASSERT_IMP(a_result_from_pop, clk, rst_n, done, $past(pop_accept))
    `RFS_ASSERT_IMP(a_empty_pop_zero, clk, rst_n, done && !out_valid, result_zero)
    `RFS_ASSERT_NXT(a_insert_bounded, clk, rst_n, busy && $past(busy), !busy)

endmodule

bind range_filter_sorted_store rfs_checker u_rfs_checker (.*);

// ===== bench/rfs_checker.sv =====
`timescale 1ns / 1ps
// Checker for range_filter_sorted_store: follows config writes and accepted commands,
// keeps its own filtered, ordered record list and compares every popped record.
// Depends on rfs_pkg.
module rfs_bench_checker
    import rfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [1:0]                command,
    input  logic [RFS_AGE_W-1:0]      rec_age,
    input  logic [RFS_WGT_W-1:0]      rec_weight,
    input  logic [RFS_LINE_W-1:0]     line_number,
    input  logic                      cfg_we,
    input  logic [RFS_CFG_IDX_W-1:0]  cfg_idx,
    input  logic [RFS_CFG_DATA_W-1:0] cfg_wdata,
    input  logic                      done,
    input  logic [RFS_AGE_W-1:0]      out_age,
    input  logic [RFS_WGT_W-1:0]      out_weight,
    input  logic [RFS_LINE_W-1:0]     out_line,
    input  logic                      out_valid,
    input  logic [RFS_REM_W-1:0]      remaining,
    input  logic                      overflow,
    output int                        fail_count,
    output int                        pops_owed
);

    typedef struct packed {
        logic [RFS_AGE_W-1:0]  age;
        logic [RFS_WGT_W-1:0]  weight;
        logic [RFS_LINE_W-1:0] line;
        logic                  valid;
        logic [RFS_REM_W-1:0]  left;
        logic                  ovf;
    } pop_result_t;

    rec_t        held[$];
    pop_result_t owed[$];

    logic [RFS_AGE_W-1:0] age_lo, age_hi;
    logic [RFS_WGT_W-1:0] wgt_lo, wgt_hi;
    logic                 by_weight, desc_order;
    logic                 ovf_seen;
    int                   fails = 0;
    pop_result_t          want, popped;

    assign fail_count = fails;

    function automatic logic [RFS_KEY_W-1:0] order_key(rec_t r);
        return by_weight ? r.weight : {{(RFS_KEY_W-RFS_AGE_W){1'b0}}, r.age};
    endfunction

    // true when a stored record stays ahead of an incoming key (ties keep arrival order)
    function automatic bit stays_ahead(logic [RFS_KEY_W-1:0] stored,
                                       logic [RFS_KEY_W-1:0] incoming);
        return desc_order ? (stored >= incoming) : (stored <= incoming);
    endfunction

    task automatic store_record(rec_t r);
        int                   pos;
        logic [RFS_KEY_W-1:0] k;
        if (r.age < age_lo || r.age > age_hi || r.weight < wgt_lo || r.weight > wgt_hi)
            return;
        if (held.size() >= RFS_DEPTH)
        begin
            ovf_seen = 1'b1;
            return;
        end
        k = order_key(r);
        pos = 0;
        while (pos < held.size() && stays_ahead(order_key(held[pos]), k))
            pos++;
        held.insert(pos, r);
    endtask

    task automatic take_first(output pop_result_t res);
        rec_t r;
        res = '0;
        if (held.size() > 0)
        begin
            r = held.pop_front();
            res.age = r.age;
            res.weight = r.weight;
            res.line = r.line;
            res.valid = 1'b1;
            res.left = RFS_REM_W'(held.size());
        end
        res.ovf = ovf_seen;
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            held.delete();
            owed.delete();
            age_lo = '0;
            age_hi = '1;
            wgt_lo = '0;
            wgt_hi = '1;
            by_weight = 1'b0;
            desc_order = 1'b0;
            ovf_seen = 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (owed.size() == 0)
                begin
                    $error("pop result with no pop outstanding");
                    fails++;
                end
                else
                begin
                    want = owed.pop_front();
                    check_field("out_age", want.age, out_age);
                    check_field("out_weight", want.weight, out_weight);
                    check_field("out_line", want.line, out_line);
                    check_field("out_valid", want.valid, out_valid);
                    check_field("remaining", want.left, remaining);
                    check_field("overflow", want.ovf, overflow);
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_AGE_LOW:     age_lo = cfg_wdata[RFS_AGE_W-1:0];
                    REG_AGE_HIGH:    age_hi = cfg_wdata[RFS_AGE_W-1:0];
                    REG_WEIGHT_LOW:  wgt_lo = cfg_wdata[RFS_WGT_W-1:0];
                    REG_WEIGHT_HIGH: wgt_hi = cfg_wdata[RFS_WGT_W-1:0];
                    REG_SORT_WEIGHT: by_weight = cfg_wdata[0];
                    REG_DESCENDING:  desc_order = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (command)
                    CMD_INSERT: store_record('{rec_age, rec_weight, line_number});
                    CMD_POP:
                    begin
                        take_first(popped);
                        owed.push_back(popped);
                    end
                    CMD_CLEAR: held.delete();
                    default: ;  // unused code, ignored
                endcase
            end
        end
        pops_owed <= owed.size();
    end

endmodule

// ===== bench/range_filter_sorted_store_tb.sv =====
`timescale 1ns / 1ps
// Top of the range_filter_sorted_store bench: clock, reset, config phases and commands.
// Depends on rfs_pkg, rfs_bench_checker and the range_filter_sorted_store RTL.
module range_filter_sorted_store_tb
    import rfs_pkg::*;
();

    localparam logic [1:0] CMD_RESERVED = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                command;
    logic [RFS_AGE_W-1:0]      rec_age;
    logic [RFS_WGT_W-1:0]      rec_weight;
    logic [RFS_LINE_W-1:0]     line_number;
    logic                      cfg_we;
    logic [RFS_CFG_IDX_W-1:0]  cfg_idx;
    logic [RFS_CFG_DATA_W-1:0] cfg_wdata;
    logic                      done;
    logic [RFS_AGE_W-1:0]      out_age;
    logic [RFS_WGT_W-1:0]      out_weight;
    logic [RFS_LINE_W-1:0]     out_line;
    logic                      out_valid;
    logic [RFS_REM_W-1:0]      remaining;
    logic                      overflow;
    int                        fail_count;
    int                        pops_owed;

    // current filter window, used to aim records at the bounds
    int unsigned age_lo_now, age_hi_now, wgt_lo_now, wgt_hi_now;
    int          burst_left;

    range_filter_sorted_store dut (.*);

    rfs_bench_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("range_filter_sorted_store: mismatch");
        $finish;
    end

    // sender bursts: random length, random gap after each burst, some bursts back to back
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(logic [1:0] cmd, logic [RFS_AGE_W-1:0] age,
                         logic [RFS_WGT_W-1:0] wgt, logic [RFS_LINE_W-1:0] line);
        start <= 1'b1;
        command <= cmd;
        rec_age <= age;
        rec_weight <= wgt;
        line_number <= line;
        @(posedge clk);
        while (busy) @(posedge clk);
        pace();
    endtask

    // stop sending, wait for outstanding pops, then let a trailing insert finish
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pops_owed != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(cfg_reg_t idx, logic [RFS_CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_filter(int unsigned alo, int unsigned ahi,
                                  int unsigned wlo, int unsigned whi,
                                  logic byw, logic dsc);
        put_reg(REG_AGE_LOW, RFS_CFG_DATA_W'(alo));
        put_reg(REG_AGE_HIGH, RFS_CFG_DATA_W'(ahi));
        put_reg(REG_WEIGHT_LOW, RFS_CFG_DATA_W'(wlo));
        put_reg(REG_WEIGHT_HIGH, RFS_CFG_DATA_W'(whi));
        put_reg(REG_SORT_WEIGHT, RFS_CFG_DATA_W'(byw));
        put_reg(REG_DESCENDING, RFS_CFG_DATA_W'(dsc));
        cfg_we <= 1'b0;
        age_lo_now = alo;
        age_hi_now = ahi;
        wgt_lo_now = wlo;
        wgt_hi_now = whi;
    endtask

    // mostly inside the window, often right on or just past an edge, small key spread for ties
    function automatic int unsigned near_bounds(int unsigned lo, int unsigned hi,
                                                int unsigned span_mask);
        int unsigned v;
        case ($urandom_range(0, 9))
            0: v = lo;
            1: v = hi;
            2: v = lo - 1;
            3: v = hi + 1;
            4: v = $urandom;
            5: v = lo + $urandom_range(0, 2);
            default: v = $urandom_range(hi, lo);
        endcase
        return v & span_mask;
    endfunction

    task automatic mixed_phase(int count);
        int pick;
        logic [1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                cmd = CMD_INSERT;
            else if (pick < 90)
                cmd = CMD_POP;
            else if (pick < 96)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_RESERVED;
            issue(cmd, RFS_AGE_W'(near_bounds(age_lo_now, age_hi_now, 32'hFF)),
                  RFS_WGT_W'(near_bounds(wgt_lo_now, wgt_hi_now, 32'hFFFFFF)),
                  RFS_LINE_W'($urandom));
        end
    endtask

    initial
    begin
        int unsigned a0, a1, w0, w1;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_INSERT;
        rec_age = '0;
        rec_weight = '0;
        line_number = '0;
        cfg_we = 1'b0;
        cfg_idx = REG_AGE_LOW;
        cfg_wdata = '0;
        burst_left = 0;
        age_lo_now = 0;
        age_hi_now = 255;
        wgt_lo_now = 0;
        wgt_hi_now = 24'hFFFFFF;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: age ascending, full windows
        issue(CMD_POP, 8'h00, 24'h000000, 32'h0);                  // empty store
        issue(CMD_INSERT, 8'd0, 24'd0, 32'd0);
        issue(CMD_INSERT, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
        issue(CMD_INSERT, 8'd40, 24'd700000, 32'd5);
        issue(CMD_INSERT, 8'd40, 24'd650000, 32'd6);               // equal age, arrives later
        issue(CMD_RESERVED, 8'd1, 24'd1, 32'd7);
        issue(CMD_INSERT, 8'd40, 24'd1, 32'd8);
        repeat (3) issue(CMD_POP, 8'h00, 24'h000000, 32'h0);
        issue(CMD_CLEAR, 8'h00, 24'h000000, 32'h0);
        issue(CMD_POP, 8'h00, 24'h000000, 32'h0);
        issue(CMD_INSERT, 8'h55, 24'h555555, 32'h55555555);
        issue(CMD_INSERT, 8'hAA, 24'hAAAAAA, 32'hAAAAAAAA);
        settle();

        // single-age window, key and direction switched with records still held
        program_filter(30, 30, 0, 24'hFFFFFF, 1'b1, 1'b1);
        issue(CMD_INSERT, 8'd29, 24'd500, 32'd20);
        issue(CMD_INSERT, 8'd30, 24'd100, 32'd21);
        issue(CMD_INSERT, 8'd31, 24'd500, 32'd22);
        issue(CMD_INSERT, 8'd30, 24'd900, 32'd23);
        repeat (3) issue(CMD_POP, 8'h00, 24'h000000, 32'h0);
        settle();

        // crossed age bounds pass nothing
        program_filter(200, 100, 0, 24'hFFFFFF, 1'b0, 1'b0);
        issue(CMD_INSERT, 8'd150, 24'd10, 32'd30);
        issue(CMD_POP, 8'h00, 24'h000000, 32'h0);
        settle();

        for (int ph = 0; ph < 10; ph++)
        begin
            a0 = $urandom_range(0, 255);
            a1 = $urandom_range(0, 255);
            w0 = $urandom_range(0, 24'hFFFFFF);
            w1 = $urandom_range(0, 24'hFFFFFF);
            case (ph)
                0: program_filter(0, 255, 0, 24'hFFFFFF, 1'b0, 1'b0);
                1: program_filter(0, 0, 0, 24'hFFFFFF, 1'b0, 1'b1);
                2: program_filter(255, 255, 0, 24'hFFFFFF, 1'b1, 1'b0);
                3: program_filter(0, 255, 500000, 900000, 1'b1, 1'b1);
                4: program_filter(0, 255, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
                5: program_filter(0, 255, 0, 0, 1'b0, 1'b1);
                6: program_filter(0, 255, 800000, 200000, 1'b1, 1'b0);
                default: program_filter(a0, a1, w0, w1, 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)));
            endcase
            mixed_phase(40);
            settle();
        end

        // fill the store to the brim, age descending so ties are common
        program_filter(0, 255, 0, 24'hFFFFFF, 1'b0, 1'b1);
        issue(CMD_CLEAR, 8'h00, 24'h000000, 32'h0);
        repeat (RFS_DEPTH)
            issue(CMD_INSERT, RFS_AGE_W'($urandom), RFS_WGT_W'($urandom),
                  RFS_LINE_W'($urandom));
        settle();

        // full store: a filtered-out record must not raise overflow
        program_filter(0, 254, 0, 24'hFFFFFF, 1'b0, 1'b1);
        issue(CMD_INSERT, 8'hFF, 24'h123456, 32'h1);
        issue(CMD_POP, 8'h00, 24'h000000, 32'h0);
        issue(CMD_INSERT, 8'd10, 24'd10, 32'h2);
        repeat (6)
            issue(CMD_INSERT, RFS_AGE_W'($urandom_range(0, 254)), RFS_WGT_W'($urandom),
                  RFS_LINE_W'($urandom));
        repeat (20)
            issue(CMD_POP, RFS_AGE_W'($urandom), RFS_WGT_W'($urandom),
                  RFS_LINE_W'($urandom));
        issue(CMD_CLEAR, 8'h00, 24'h000000, 32'h0);
        issue(CMD_POP, 8'h00, 24'h000000, 32'h0);                  // overflow stays set
        repeat (4)
            issue(CMD_INSERT, RFS_AGE_W'($urandom_range(0, 254)), RFS_WGT_W'($urandom),
                  RFS_LINE_W'($urandom));
        repeat (5) issue(CMD_POP, 8'h00, 24'h000000, 32'h0);

        start <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < 1000 && pops_owed != 0; n++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pops_owed == 0)
            $display("range_filter_sorted_store: match");
        else
            $display("range_filter_sorted_store: mismatch");
        $finish;
    end

endmodule
